FILE: src/audio_segment_envelope_lookup_top_defines.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef AUDIO_SEGMENT_ENVELOPE_LOOKUP_TOP_DEFINES_SVH
`define AUDIO_SEGMENT_ENVELOPE_LOOKUP_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ASEL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define ASEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

FILE: src/asel_pkg.sv
// shared constants and helpers for the segment envelope lookup
// no dependencies
package asel_pkg;
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] KIND_AUDIBLE = 2'd0;
  localparam logic [1:0] KIND_MUTED   = 2'd1;
  localparam logic [1:0] SHAPE_LINEAR = 2'd0;
  localparam logic [1:0] SHAPE_SMOOTH = 2'd1;
  localparam logic [1:0] SHAPE_SINE   = 2'd2;
  localparam int unsigned Q16_ONE = 65536;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // quarter-sine sample k of n points, Q16, evaluated at elaboration
  function automatic logic [16:0] sine_point(input int unsigned k, input int unsigned n);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    logic [63:0] q;
    sum = 0;
    x = (64'(k) * HALF_PI_Q30) / 64'(n);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    q = (sum > 0) ? ((64'(sum) + 64'd8192) >> 14) : 64'd0;
    if (q > 64'(Q16_ONE)) q = 64'(Q16_ONE);
    if (k == 0) q = 64'd0;
    if (k == n) q = 64'(Q16_ONE);
    return q[16:0];
  endfunction
endpackage

FILE: src/audio_segment_envelope_lookup_top.sv
// segment table, binary search and fixed-point envelope unit
// depends on asel_pkg
//
// usage: in_* carries one command beat (clear, append or query). clear and
// append give no result. a query gives exactly one out_* beat with emitted,
// muted, Q2.16 amplitude and the gap after the segment's last frame.
// an append goes through a write state, a clear does not. a query runs a
// binary search, one table read per step (up to log2(MAX_SEGMENTS)+1 steps),
// then a fetch, then up to four factors. each factor runs a 17-step restoring
// division in one shared subtract unit, then up to four multiply steps of one
// 32x32 multiplier (curve, scale).
// in_stall is high whenever the sequencer is busy or the result is held.
// the result waits in the output register while out_stall is high; the
// block then stays busy until it is taken.
// reset clears the segment count and the sequencer; the table memories keep
// whatever they held, and only entries below the count are ever used.
// the sine table is a constant of SINE_POINTS+1 entries built at elaboration.
module audio_segment_envelope_lookup_top #(
  parameter int MAX_SEGMENTS = 128,
  parameter int FRAME_BITS = 40,
  parameter int SINE_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [FRAME_BITS-1:0] in_frame_pos,
  input  logic [FRAME_BITS-1:0] in_seg_end,
  input  logic [1:0]  in_seg_kind,
  input  logic [17:0] in_seg_gain,
  input  logic [39:0] in_fade_in_len,
  input  logic [39:0] in_fade_out_len,
  input  logic [1:0]  in_fade_in_shape,
  input  logic [1:0]  in_fade_out_shape,
  input  logic [29:0] in_gap_len,
  input  logic [19:0] in_join_in_len,
  input  logic [19:0] in_join_out_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_emitted,
  output logic        out_muted,
  output logic [17:0] out_amplitude,
  output logic [29:0] out_gap_out
);
  import asel_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int FW = FRAME_BITS;
  // fade lengths stored at the smaller of 40 bits and the frame width
  localparam int LW = (FW < 40) ? FW : 40;
  localparam int SW = $clog2(SINE_POINTS);
  localparam int DW = FW + 1;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SRD   = 5'd1;
  localparam logic [4:0] ST_SCMP  = 5'd2;
  localparam logic [4:0] ST_FRD   = 5'd3;
  localparam logic [4:0] ST_FCHK  = 5'd4;
  localparam logic [4:0] ST_FSEL  = 5'd5;
  localparam logic [4:0] ST_DIV   = 5'd6;
  localparam logic [4:0] ST_CRV1  = 5'd7;
  localparam logic [4:0] ST_CRV2  = 5'd8;
  localparam logic [4:0] ST_CRV3  = 5'd9;
  localparam logic [4:0] ST_SIN1  = 5'd10;
  localparam logic [4:0] ST_SIN2  = 5'd11;
  localparam logic [4:0] ST_SCL   = 5'd12;
  localparam logic [4:0] ST_OUT   = 5'd13;
  localparam logic [4:0] ST_WR    = 5'd14;

  // sine table, constant
  logic [16:0] sine_rom [SINE_POINTS+1];
  for (genvar g = 0; g <= SINE_POINTS; g++) begin : g_sine
    assign sine_rom[g] = sine_point(g, SINE_POINTS);
  end

  // table memories
  logic [FW-1:0] start_mem [MAX_SEGMENTS];
  logic [FW-1:0] end_mem [MAX_SEGMENTS];
  logic [19:0]   kg_mem [MAX_SEGMENTS];
  logic [LW+1:0] fin_mem [MAX_SEGMENTS];
  logic [LW+1:0] fout_mem [MAX_SEGMENTS];
  logic [29:0]   gap_mem [MAX_SEGMENTS];
  logic [39:0]   join_mem [MAX_SEGMENTS];

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [FW-1:0] frame_r;
  logic [CW-1:0] first_r, len_r;
  logic [AW-1:0] raddr;
  logic [FW-1:0] rd_end_r, rd_start_r;
  logic [19:0]   rd_kg_r;
  logic [LW+1:0] rd_fin_r, rd_fout_r;
  logic [29:0]   rd_gap_r;
  logic [39:0]   rd_join_r;
  logic [1:0]    fac_r;
  logic [DW-1:0] num_r, den_r, rem_r;
  logic [16:0]   q_r;
  logic [4:0]    step_r;
  logic [1:0]    shape_r;
  logic [63:0]   prod_r;
  logic [16:0]   p_r;
  logic [16:0]   f_r;
  logic [17:0]   amp_r;
  logic          emit_r, mute_r;
  logic [29:0]   gapo_r;
  logic          ov_r;

  // append staging
  logic [FW-1:0] a_start_r, a_end_r;
  logic [19:0]   a_kg_r;
  logic [LW+1:0] a_fin_r, a_fout_r;
  logic [29:0]   a_gap_r;
  logic [39:0]   a_join_r;

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic [CW-1:0] half;
  assign half = len_r >> 1;
  logic [CW-1:0] probe;
  assign probe = first_r + half;
  assign raddr = (state_r == ST_SRD) ? probe[AW-1:0] : first_r[AW-1:0];

  logic [FW-1:0] offset, remaining;
  assign offset = frame_r - rd_start_r;
  assign remaining = rd_end_r - frame_r;

  // factor selection
  logic [FW-1:0] f_len;
  logic          f_act;
  logic [1:0]    f_shape;
  logic [FW-1:0] f_num;
  always_comb begin
    f_len = '0;
    f_num = offset;
    f_shape = SHAPE_LINEAR;
    case (fac_r)
      2'd0: begin
        f_len = FW'(rd_fin_r[LW-1:0]);
        f_shape = rd_fin_r[LW+1:LW];
      end
      2'd1: begin
        f_len = FW'(rd_fout_r[LW-1:0]);
        f_shape = rd_fout_r[LW+1:LW];
        f_num = remaining;
      end
      2'd2: f_len = FW'(rd_join_r[39:20]);
      default: begin
        f_len = FW'(rd_join_r[19:0]);
        f_num = remaining;
      end
    endcase
    if (fac_r[0]) f_act = (f_len != '0) && (remaining <= f_len);
    else f_act = (f_len != '0) && (offset < f_len);
  end

  // restoring divider step, shared subtractor
  logic [DW-1:0] dsub;
  logic          dge;
  assign dsub = rem_r - (den_r - rem_r);
  assign dge = rem_r >= (den_r - rem_r);

  // sine index from p*SINE_POINTS
  logic [16+SW:0] sp;
  logic [SW:0]    sidx;
  logic [15:0]    sfr;
  assign sp = (16+SW+1)'(p_r) << SW;
  assign sidx = sp[16+SW:16];
  assign sfr = sp[15:0];
  logic [16:0] sa, sb;
  assign sa = sine_rom[sidx];
  assign sb = (sidx >= (SW+1)'(SINE_POINTS)) ? sa : sine_rom[sidx + 1'b1];
  logic [16:0] sdiff;
  assign sdiff = (sb >= sa) ? (sb - sa) : (sa - sb);

  logic [31:0] smooth_t;
  assign smooth_t = 32'(3 * Q16_ONE) - (32'(p_r) << 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_CRV1: begin mul_a = 32'(p_r); mul_b = 32'(p_r); end
      ST_CRV2: begin mul_a = prod_r[31:0]; mul_b = smooth_t; end
      ST_CRV3: begin mul_a = prod_r[63:32]; mul_b = smooth_t; end
      ST_SIN1: begin mul_a = 32'(sdiff); mul_b = 32'(sfr); end
      ST_SCL:  begin mul_a = 32'(amp_r); mul_b = 32'(f_r); end
      default: ;
    endcase
  end

  wire in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) begin
        if (in_cmd == CMD_APPEND) state_nxt = ST_WR;
        else if (in_cmd == CMD_QUERY) state_nxt = ST_SRD;
      end
      ST_WR: state_nxt = ST_IDLE;
      ST_SRD: state_nxt = (len_r == '0) ? ST_FRD : ST_SCMP;
      ST_SCMP: state_nxt = ST_SRD;
      ST_FRD: state_nxt = ST_FCHK;
      // only a covered audible frame goes on to the envelope factors
      ST_FCHK: begin
        if (first_r < count_r && frame_r >= rd_start_r && rd_kg_r[19:18] == KIND_AUDIBLE)
          state_nxt = ST_FSEL;
        else state_nxt = ST_OUT;
      end
      ST_FSEL: begin
        if (f_act) state_nxt = ST_DIV;
        else if (fac_r == 2'd3) state_nxt = ST_OUT;
      end
      ST_DIV: if (step_r == 5'd16) begin
        if (fac_r[1] || shape_r == SHAPE_LINEAR || shape_r == 2'd3) state_nxt = ST_SCL;
        else if (shape_r == SHAPE_SMOOTH) state_nxt = ST_CRV1;
        else state_nxt = ST_SIN1;
      end
      ST_CRV1: state_nxt = ST_CRV2;
      ST_CRV2: state_nxt = ST_CRV3;
      ST_CRV3: state_nxt = ST_SCL;
      ST_SIN1: state_nxt = ST_SIN2;
      ST_SIN2: state_nxt = ST_SCL;
      ST_SCL: state_nxt = (fac_r == 2'd3) ? ST_OUT : ST_FSEL;
      // hold until the result beat is taken
      ST_OUT: if (ov_r && !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == ST_WR && count_r < CW'(MAX_SEGMENTS)) begin
      start_mem[count_r[AW-1:0]] <= a_start_r;
      end_mem[count_r[AW-1:0]]   <= a_end_r;
      kg_mem[count_r[AW-1:0]]    <= a_kg_r;
      fin_mem[count_r[AW-1:0]]   <= a_fin_r;
      fout_mem[count_r[AW-1:0]]  <= a_fout_r;
      gap_mem[count_r[AW-1:0]]   <= a_gap_r;
      join_mem[count_r[AW-1:0]]  <= a_join_r;
    end
    rd_end_r   <= end_mem[raddr];
    rd_start_r <= start_mem[raddr];
    rd_kg_r    <= kg_mem[raddr];
    rd_fin_r   <= fin_mem[raddr];
    rd_fout_r  <= fout_mem[raddr];
    rd_gap_r   <= gap_mem[raddr];
    rd_join_r  <= join_mem[raddr];
  end

  // output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == ST_OUT && !ov_r) begin
      ov_r <= 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_cmd == CMD_CLEAR) count_r <= '0;
      if (state_r == ST_WR && count_r < CW'(MAX_SEGMENTS)) count_r <= count_r + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        frame_r <= in_frame_pos;
        first_r <= '0;
        len_r <= count_r;
        a_start_r <= in_frame_pos;
        a_end_r <= in_seg_end;
        a_kg_r <= {in_seg_kind, in_seg_gain};
        a_fin_r <= {in_fade_in_shape, in_fade_in_len[LW-1:0]};
        a_fout_r <= {in_fade_out_shape, in_fade_out_len[LW-1:0]};
        a_gap_r <= in_gap_len;
        a_join_r <= {in_join_in_len, in_join_out_len};
        emit_r <= 1'b0;
        mute_r <= 1'b0;
        amp_r <= '0;
        gapo_r <= '0;
      end
      ST_SCMP: begin
        if (frame_r < rd_end_r) begin
          len_r <= half;
        end else begin
          first_r <= probe + 1'b1;
          len_r <= len_r - half - 1'b1;
        end
      end
      ST_FCHK: begin
        fac_r <= 2'd0;
        if (first_r < count_r && frame_r >= rd_start_r) begin
          if (frame_r + 1'b1 == rd_end_r) gapo_r <= rd_gap_r;
          if (rd_kg_r[19:18] == KIND_MUTED) begin
            emit_r <= 1'b1;
            mute_r <= 1'b1;
          end else if (rd_kg_r[19:18] == KIND_AUDIBLE) begin
            emit_r <= 1'b1;
            amp_r <= rd_kg_r[17:0];
          end
        end
      end
      ST_FSEL: begin
        shape_r <= f_shape;
        den_r <= DW'(f_len);
        step_r <= '0;
        if (DW'(f_num) >= DW'(f_len)) begin
          q_r <= 17'd1;
          rem_r <= DW'(f_num) - DW'(f_len);
        end else begin
          q_r <= '0;
          rem_r <= DW'(f_num);
        end
        if (!f_act) fac_r <= fac_r + 1'b1;
      end
      ST_DIV: begin
        step_r <= step_r + 1'b1;
        if (dge) begin
          rem_r <= dsub;
          q_r <= {q_r[15:0], 1'b1};
        end else begin
          rem_r <= rem_r << 1;
          q_r <= {q_r[15:0], 1'b0};
        end
        if (step_r == 5'd16) begin
          p_r <= q_r;
          f_r <= q_r;
        end
      end
      ST_CRV1: prod_r <= mul_p;
      ST_CRV2: prod_r <= {prod_r[63:32], mul_p[63:32]};
      ST_CRV3: f_r <= 17'((mul_p + 64'(prod_r[31:0])) >> 0);
      ST_SIN1: prod_r <= mul_p;
      ST_SIN2: begin
        if (sidx >= (SW+1)'(SINE_POINTS)) f_r <= sa;
        else if (sb >= sa) f_r <= sa + 17'(prod_r[63:16]);
        else f_r <= sa - 17'(prod_r[63:16]);
      end
      ST_SCL: begin
        amp_r <= 18'(mul_p >> 16);
        fac_r <= fac_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_emitted = emit_r;
  assign out_muted = mute_r;
  assign out_amplitude = amp_r;
  assign out_gap_out = gapo_r;
endmodule

FILE: src/asel_checker.sv
// port-level checker for the segment envelope lookup, bound to the top level
// depends on audio_segment_envelope_lookup_top_defines.svh
`include "audio_segment_envelope_lookup_top_defines.svh"
module asel_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_emitted,
  input logic out_muted,
  input logic [17:0] out_amplitude
);
  `ASEL_ASSERT_IMP(a_mute_emit, out_valid && out_muted, out_emitted)
  `ASEL_ASSERT_IMP(a_mute_amp, out_valid && out_muted, out_amplitude == 18'd0)
  `ASEL_ASSERT_IMP(a_hidden_amp, out_valid && !out_emitted, out_amplitude == 18'd0)
  `ASEL_ASSERT_IMP(a_busy_out, out_valid, in_stall)
  `ASEL_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
endmodule

bind audio_segment_envelope_lookup_top asel_checker u_asel_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_emitted(out_emitted),
  .out_muted(out_muted), .out_amplitude(out_amplitude)
);

FILE: test/asel_envelope_checker.sv
// checker for the segment envelope lookup: watches both beat channels,
// predicts each query result and compares it with what the block returns
// depends on asel_pkg
`timescale 1ns / 100ps

module asel_envelope_checker
  import asel_pkg::*;
#(
  parameter int MAX_SEGMENTS = 128,
  parameter int SINE_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [39:0] in_frame_pos,
  input  logic [39:0] in_seg_end,
  input  logic [1:0]  in_seg_kind,
  input  logic [17:0] in_seg_gain,
  input  logic [39:0] in_fade_in_len,
  input  logic [39:0] in_fade_out_len,
  input  logic [1:0]  in_fade_in_shape,
  input  logic [1:0]  in_fade_out_shape,
  input  logic [29:0] in_gap_len,
  input  logic [19:0] in_join_in_len,
  input  logic [19:0] in_join_out_len,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_emitted,
  input  logic        out_muted,
  input  logic [17:0] out_amplitude,
  input  logic [29:0] out_gap_out,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    logic        emitted;
    logic        muted;
    logic [17:0] amplitude;
    logic [29:0] gap_out;
  } envelope_t;

  typedef struct {
    logic [39:0] first_frame;
    logic [39:0] stop_frame;
    logic [1:0]  kind;
    logic [17:0] gain;
    logic [39:0] fin_len;
    logic [1:0]  fin_shape;
    logic [39:0] fout_len;
    logic [1:0]  fout_shape;
    logic [29:0] gap;
    logic [19:0] jin_len;
    logic [19:0] jout_len;
  } segment_t;

  segment_t    segments [MAX_SEGMENTS];
  int unsigned seg_count;
  logic [16:0] quarter_sine [SINE_POINTS+1];
  envelope_t   envelope_queue [$];

  assign pending = envelope_queue.size();

  // quarter-sine table, taylor series in Q30 rounded to Q16
  initial begin
    logic [63:0] x, x2, term, q;
    longint acc;
    for (int k = 0; k <= SINE_POINTS; k++) begin
      x = (64'(k) * HALF_PI_Q30) / 64'(SINE_POINTS);
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      q = (acc > 0) ? ((64'(acc) + 64'd8192) >> 14) : 64'd0;
      if (q > 64'(Q16_ONE)) q = 64'(Q16_ONE);
      quarter_sine[k] = q[16:0];
    end
    quarter_sine[0] = '0;
    quarter_sine[SINE_POINTS] = 17'(Q16_ONE);
  end

  function automatic logic [63:0] progress_q16(logic [63:0] num, logic [63:0] den);
    return (num << 16) / den;
  endfunction

  function automatic logic [63:0] fade_curve(logic [63:0] p, logic [1:0] shape);
    logic [63:0] s, idx, fr, a, b;
    case (shape)
      SHAPE_SMOOTH: begin
        return (p * p * (64'd196608 - 2 * p)) >> 32;
      end
      SHAPE_SINE: begin
        s = p * SINE_POINTS;
        idx = s >> 16;
        fr = s & 64'hFFFF;
        if (idx >= SINE_POINTS) return 64'(quarter_sine[SINE_POINTS]);
        a = 64'(quarter_sine[idx]);
        b = 64'(quarter_sine[idx + 1]);
        if (b >= a) return a + (((b - a) * fr) >> 16);
        return a - (((a - b) * fr) >> 16);
      end
      default: return p;
    endcase
  endfunction

  function automatic envelope_t lookup_envelope(logic [39:0] frame);
    envelope_t   res;
    segment_t    seg;
    int unsigned lo, span, half;
    logic [63:0] amp, offset, remaining, len;
    res = '0;
    lo = 0;
    span = seg_count;
    // upper-bound search on segment ends
    while (span > 0) begin
      half = span / 2;
      if (frame < segments[lo + half].stop_frame) span = half;
      else begin
        lo = lo + half + 1;
        span = span - half - 1;
      end
    end
    if (lo >= seg_count) return res;
    seg = segments[lo];
    if (frame < seg.first_frame) return res;
    if (41'(frame) + 41'd1 == 41'(seg.stop_frame)) res.gap_out = seg.gap;
    if (seg.kind >= 2) return res;
    res.emitted = 1'b1;
    if (seg.kind == KIND_MUTED) begin
      res.muted = 1'b1;
      return res;
    end
    amp = 64'(seg.gain);
    offset = 64'(frame) - 64'(seg.first_frame);
    remaining = 64'(seg.stop_frame) - 64'(frame);
    len = 64'(seg.fin_len);
    if (len > 0 && offset < len)
      amp = (amp * fade_curve(progress_q16(offset, len), seg.fin_shape)) >> 16;
    len = 64'(seg.fout_len);
    if (len > 0 && remaining <= len)
      amp = (amp * fade_curve(progress_q16(remaining, len), seg.fout_shape)) >> 16;
    len = 64'(seg.jin_len);
    if (len > 0 && offset < len) amp = (amp * progress_q16(offset, len)) >> 16;
    len = 64'(seg.jout_len);
    if (len > 0 && remaining <= len) amp = (amp * progress_q16(remaining, len)) >> 16;
    res.amplitude = amp[17:0];
    return res;
  endfunction

  always @(posedge clk) begin
    envelope_t want;
    if (!rst_n) begin
      seg_count <= 0;
      failures <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        case (in_cmd)
          CMD_CLEAR: seg_count <= 0;
          CMD_APPEND: begin
            if (seg_count < MAX_SEGMENTS) begin
              segments[seg_count] <= '{in_frame_pos, in_seg_end, in_seg_kind, in_seg_gain,
                                       in_fade_in_len, in_fade_in_shape, in_fade_out_len,
                                       in_fade_out_shape, in_gap_len, in_join_in_len,
                                       in_join_out_len};
              seg_count <= seg_count + 1;
            end
          end
          CMD_QUERY: envelope_queue.insert(envelope_queue.size(),
                                           lookup_envelope(in_frame_pos));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (envelope_queue.size() == 0) begin
          $error("result beat with nothing expected");
          failures <= failures + 1;
        end else begin
          want = envelope_queue.pop_front();
          if (out_emitted !== want.emitted || out_muted !== want.muted ||
              out_amplitude !== want.amplitude || out_gap_out !== want.gap_out)
            failures <= failures + 1;
          if (out_emitted !== want.emitted)
            $error("emitted expected %0d got %0d", want.emitted, out_emitted);
          if (out_muted !== want.muted)
            $error("muted expected %0d got %0d", want.muted, out_muted);
          if (out_amplitude !== want.amplitude)
            $error("amplitude expected %0d got %0d", want.amplitude, out_amplitude);
          if (out_gap_out !== want.gap_out)
            $error("gap_out expected %0d got %0d", want.gap_out, out_gap_out);
        end
      end
    end
  end

endmodule

FILE: test/tb_audio_segment_envelope_lookup_top.sv
// top of the envelope lookup testbench: clock, reset, command beats and verdict
// depends on asel_pkg, audio_segment_envelope_lookup_top and asel_envelope_checker
`timescale 1ns / 100ps

module tb_audio_segment_envelope_lookup_top;
  import asel_pkg::*;

  localparam int MAX_SEG = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] CMD_IGNORED = 2'd3; // unused command code
  localparam logic [1:0] KIND_HIDDEN = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;  // behaves as hidden
  localparam logic [1:0] SHAPE_SPARE = 2'd3; // behaves as linear

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [39:0] in_frame_pos;
  logic [39:0] in_seg_end;
  logic [1:0]  in_seg_kind;
  logic [17:0] in_seg_gain;
  logic [39:0] in_fade_in_len;
  logic [39:0] in_fade_out_len;
  logic [1:0]  in_fade_in_shape;
  logic [1:0]  in_fade_out_shape;
  logic [29:0] in_gap_len;
  logic [19:0] in_join_in_len;
  logic [19:0] in_join_out_len;
  logic        out_valid;
  logic        out_stall;
  logic        out_emitted;
  logic        out_muted;
  logic [17:0] out_amplitude;
  logic [29:0] out_gap_out;

  int failures;
  int pending;
  int cycles;
  int beats_sent;
  bit no_idle; // set for a stretch where neither side idles

  audio_segment_envelope_lookup_top #(
    .MAX_SEGMENTS(MAX_SEG),
    .FRAME_BITS(40),
    .SINE_POINTS(256)
  ) DUT (.*);

  asel_envelope_checker #(
    .MAX_SEGMENTS(MAX_SEG),
    .SINE_POINTS(256)
  ) checker_i (.*);

  // free-running clock, 12 ns
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back-pressure, about 27 percent of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 27);
    end
  end

  function automatic logic [39:0] rand40();
    return {$urandom(), $urandom()};
  endfunction

  // one command beat; an optional idle gap comes first, then hold until accepted
  task automatic send_beat(logic [1:0] cmd, logic [39:0] pos, logic [39:0] seg_end,
                           logic [1:0] kind, logic [17:0] gain, logic [39:0] fin,
                           logic [39:0] fout, logic [1:0] fin_shape,
                           logic [1:0] fout_shape, logic [29:0] gap,
                           logic [19:0] jin, logic [19:0] jout);
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_cmd <= cmd;
    in_frame_pos <= pos;
    in_seg_end <= seg_end;
    in_seg_kind <= kind;
    in_seg_gain <= gain;
    in_fade_in_len <= fin;
    in_fade_out_len <= fout;
    in_fade_in_shape <= fin_shape;
    in_fade_out_shape <= fout_shape;
    in_gap_len <= gap;
    in_join_in_len <= jin;
    in_join_out_len <= jout;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != CMD_IGNORED) beats_sent++;
  endtask

  task automatic send_query(logic [39:0] pos);
    send_beat(CMD_QUERY, pos, rand40(), 2'($urandom()), 18'($urandom()), rand40(),
              rand40(), 2'($urandom()), 2'($urandom()), 30'($urandom()),
              20'($urandom()), 20'($urandom()));
  endtask

  // fully random beat, any command code
  task automatic send_noise();
    send_beat(2'($urandom()), rand40(), rand40(), 2'($urandom()), 18'($urandom()),
              rand40(), rand40(), 2'($urandom()), 2'($urandom()), 30'($urandom()),
              20'($urandom()), 20'($urandom()));
  endtask

  // clear, append a run of contiguous segments, then query around them
  task automatic table_and_queries(int n_seg, int n_query, int max_len);
    logic [39:0] base, cursor, seg_len;
    logic [1:0]  kind;
    logic [39:0] fin, fout;
    logic [19:0] jin, jout;
    base = ($urandom_range(0, 3) == 0) ? 40'hFF_FFFF_FFFF - 40'(n_seg * max_len) - 40'd8
                                       : rand40() >> $urandom_range(0, 39);
    cursor = base;
    send_beat(CMD_CLEAR, rand40(), rand40(), 2'($urandom()), 18'($urandom()), rand40(),
              rand40(), 2'($urandom()), 2'($urandom()), 30'($urandom()),
              20'($urandom()), 20'($urandom()));
    for (int s = 0; s < n_seg; s++) begin
      seg_len = 40'($urandom_range(1, max_len));
      kind = ($urandom_range(0, 9) < 6) ? KIND_AUDIBLE : 2'($urandom());
      // fades mostly comparable to the segment, now and then huge
      fin = ($urandom_range(0, 9) == 0) ? rand40() : 40'($urandom_range(0, max_len + 4));
      fout = ($urandom_range(0, 9) == 0) ? rand40() : 40'($urandom_range(0, max_len + 4));
      jin = ($urandom_range(0, 9) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 12));
      jout = ($urandom_range(0, 9) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 12));
      send_beat(CMD_APPEND, cursor, cursor + seg_len, kind, 18'($urandom()), fin, fout,
                2'($urandom()), 2'($urandom()), 30'($urandom()), jin, jout);
      cursor = cursor + seg_len;
      // occasional hole leaves frames uncovered
      if ($urandom_range(0, 19) == 0) cursor = cursor + 40'($urandom_range(1, 3));
    end
    for (int q = 0; q < n_query; q++)
      send_query(base - 40'd2 + 40'($urandom_range(0, 32'(cursor - base) + 4)));
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    cycles <= 0;
    beats_sent = 0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_CLEAR;
    in_frame_pos <= '0;
    in_seg_end <= '0;
    in_seg_kind <= KIND_AUDIBLE;
    in_seg_gain <= '0;
    in_fade_in_len <= '0;
    in_fade_out_len <= '0;
    in_fade_in_shape <= SHAPE_LINEAR;
    in_fade_out_shape <= SHAPE_LINEAR;
    in_gap_len <= '0;
    in_join_in_len <= '0;
    in_join_out_len <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, then one of each segment kind and shape
    send_query(40'd0);
    send_beat(CMD_APPEND, 40'd0, 40'd20, KIND_AUDIBLE, 18'h3FFFF, 40'd8, 40'd8,
              SHAPE_SMOOTH, SHAPE_SINE, 30'h3FFF_FFFF, 20'd4, 20'd4);
    send_beat(CMD_APPEND, 40'd20, 40'd30, KIND_MUTED, 18'h3FFFF, 40'd0, 40'd0,
              SHAPE_LINEAR, SHAPE_LINEAR, 30'd7, 20'd0, 20'd0);
    send_beat(CMD_APPEND, 40'd30, 40'd40, KIND_HIDDEN, 18'd65536, 40'd3, 40'd3,
              SHAPE_LINEAR, SHAPE_LINEAR, 30'd9, 20'd0, 20'd0);
    send_beat(CMD_APPEND, 40'd40, 40'd50, KIND_SPARE, 18'd65536, 40'd3, 40'd3,
              SHAPE_LINEAR, SHAPE_LINEAR, 30'd11, 20'd0, 20'd0);
    send_beat(CMD_APPEND, 40'd52, 40'hFF_FFFF_FFFF, KIND_AUDIBLE, 18'd65536,
              40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, SHAPE_SPARE, SHAPE_SINE, 30'd0,
              20'hFFFFF, 20'hFFFFF);
    send_query(40'd0);   // fade-in start
    send_query(40'd5);   // inside the fade-in
    send_query(40'd19);  // last frame, gap reported
    send_query(40'd25);  // muted
    send_query(40'd29);  // muted last frame
    send_query(40'd39);  // hidden last frame
    send_query(40'd45);  // spare kind
    send_query(40'd51);  // hole, uncovered
    send_query(40'hFF_FFFF_FFFE);
    send_query(40'hFF_FFFF_FFFF); // beyond every end
    send_beat(CMD_IGNORED, 40'd5, '0, KIND_AUDIBLE, '0, '0, '0, SHAPE_LINEAR,
              SHAPE_LINEAR, '0, '0, '0);
    send_beat(CMD_CLEAR, '0, '0, KIND_AUDIBLE, '0, '0, '0, SHAPE_LINEAR, SHAPE_LINEAR,
              '0, '0, '0);
    send_query(40'd5);

    // fill past capacity, extra appends must be dropped
    table_and_queries(MAX_SEG + 3, 20, 2);

    // pause until every query has been answered
    wait_drained();
    repeat (150) @(posedge clk);

    // stretch with no idling on either side
    no_idle = 1'b1;
    table_and_queries(10, 25, 30);
    no_idle = 1'b0;

    while (beats_sent < 500) begin
      if ($urandom_range(0, 9) < 8)
        table_and_queries($urandom_range(1, 14), $urandom_range(4, 20),
                          ($urandom_range(0, 4) == 0) ? 300 : 40);
      else
        repeat ($urandom_range(2, 6)) send_noise();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (150) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
